// ----- src/tint_and_alpha_over_compositor_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the tint and alpha-over compositor
// Clocked, reset-gated concurrent check helpers.
// ---------------------------------------------------------------------------
`ifndef TINT_AND_ALPHA_OVER_COMPOSITOR_ASSERT_SVH
`define TINT_AND_ALPHA_OVER_COMPOSITOR_ASSERT_SVH

// Check a property at every rising clk edge, skipped while in reset.
`define TAO_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same check, for a property that holds in the cycle after its trigger.
`define TAO_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

// ----- src/tao_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tao_pkg
// Shared types, codes and arithmetic helpers of the compositor.
// ---------------------------------------------------------------------------
package tao_pkg;

	localparam int PIX_W  = 32;
	localparam int TINT_W = 24;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_COPY      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_OVER      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TINT      = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TINT_OVER = 2'd3;

	localparam logic [0:0] REG_MODE = 1'b0;
	localparam logic [0:0] REG_TINT = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TINT_W-1:0] tint;
		logic [PIX_W-1:0]  src;
		logic [PIX_W-1:0]  dst;
	} ctx_t;

	// floor(y / 255) for y <= 65279: reciprocal estimate, then one correction
	function automatic logic [7:0] div255(input logic [15:0] y);
		logic [24:0] p;
		logic [8:0]  q0;
		logic [16:0] r;
		p  = {1'b0, y, 8'd0} + 25'(y);
		q0 = p[24:16];
		r  = 17'(y) - (17'({q0, 8'd0}) - 17'(q0));
		if (r >= 17'd255) begin
			div255 = 8'(q0 + 9'd1);
		end else begin
			div255 = q0[7:0];
		end
	endfunction

	// tint numerator; never exceeds 32640
	function automatic logic [14:0] tint_num(input logic [7:0] t, input logic [7:0] lum);
		logic [16:0] hi;
		logic [16:0] lo;
		hi = 17'(16'(8'd255 - t) * 16'(lum)) + 17'({t, 8'd0}) - 17'd32640;
		lo = 17'(16'(t) * 16'(lum));
		if (lum > 8'd128) begin
			tint_num = hi[14:0];
		end else begin
			tint_num = lo[14:0];
		end
	endfunction

endpackage

// ----- src/tao_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tao_in_if / tao_out_if
// Valid/ready channels carrying pixel items.
// ---------------------------------------------------------------------------
interface tao_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_pixel;
	logic [31:0] dst_pixel;
	modport source (output valid, output src_pixel, output dst_pixel, input ready);
	modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface tao_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_pixel;
	modport source (output valid, output out_pixel, input ready);
	modport sink   (input valid, input out_pixel, output ready);
endinterface

// ----- src/tint_and_alpha_over_compositor.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tint_and_alpha_over_compositor
// Ten-stage premultiplied ARGB compositor: copy, over, tint, tint+over.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per pixel: src_pixel and dst_pixel (ARGB, alpha
//   in bits 31:24). out_ch returns one out_pixel for every item, in order.
//   cfg_we/cfg_addr/cfg_wdata write mode (index 0) and tint_color (index 1);
//   write them only while the pipe is empty.
// Path: an item accepted on in_ch is registered in stages 1 to 10 and
//   leaves on out_ch from the stage 10 output register.
// Throughput: one item per clock unless stalled; the depth is set by the lum
//   division (two quotient bits per stage over four stages) and the multiply chain.
// Stall: the whole pipe holds when the output register is full and not
//   taken; in_ch.ready then drops, nothing is lost or repeated.
// Reset: all valid bits clear, mode returns to alpha over, tint to zero.
// ---------------------------------------------------------------------------
module tint_and_alpha_over_compositor
	import tao_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_addr,
	input  logic [TINT_W-1:0] cfg_wdata,
	tao_in_if.sink            in_ch,
	tao_out_if.source         out_ch
);

	`include "tint_and_alpha_over_compositor_assert.svh"

	localparam int NS = 10;

	// configuration registers
	logic [MODE_W-1:0] mode_q;
	logic [TINT_W-1:0] tint_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OVER;
			tint_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MODE: mode_q <= cfg_wdata[MODE_W-1:0];
				REG_TINT: tint_q <= cfg_wdata;
				default:  mode_q <= mode_q;
			endcase
		end
	end

	// global advance: the pipe moves unless the output item is stuck
	logic          en;
	logic [NS:1]   v_s;
	ctx_t          ctx_s [1:NS-1];

	assign en           = !v_s[NS] || out_ch.ready;
	assign in_ch.ready  = en;
	assign out_ch.valid = v_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NS-1:1], in_ch.valid};
		end
	end

	// stage 1: N = r*255, start of long division N / a
	logic [7:0]  div_rem_s [1:5];
	logic [7:0]  div_n_s   [1:5];
	logic [7:0]  div_q_s   [1:5];
	logic        lum_sat_s [1:5];
	logic        a_zero_s  [1:5];
	logic [15:0] n_in;
	logic [7:0]  a_in;
	logic [7:0]  r_in;

	assign a_in = in_ch.src_pixel[31:24];
	assign r_in = in_ch.src_pixel[23:16];
	assign n_in = {r_in, 8'd0} - 16'(r_in);

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[1]     <= {mode_q, tint_q, in_ch.src_pixel, in_ch.dst_pixel};
			div_rem_s[1] <= n_in[15:8];
			div_n_s[1]   <= n_in[7:0];
			div_q_s[1]   <= '0;
			lum_sat_s[1] <= (r_in >= a_in);
			a_zero_s[1]  <= (a_in == 8'd0);
		end
	end

	// stages 2..5: two restoring-division steps each
	for (genvar g = 2; g <= 5; g++) begin : g_div
		logic [7:0] rem_c;
		logic [7:0] n_c;
		logic [7:0] q_c;
		logic [8:0] t;
		logic [7:0] a;

		always_comb begin
			a     = ctx_s[g-1].src[31:24];
			rem_c = div_rem_s[g-1];
			n_c   = div_n_s[g-1];
			q_c   = div_q_s[g-1];
			for (int k = 0; k < 2; k++) begin
				t = {rem_c, n_c[7]};
				n_c = {n_c[6:0], 1'b0};
				if (t >= 9'(a)) begin
					rem_c = 8'(t - 9'(a));
					q_c   = {q_c[6:0], 1'b1};
				end else begin
					rem_c = t[7:0];
					q_c   = {q_c[6:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[g]     <= ctx_s[g-1];
				div_rem_s[g] <= rem_c;
				div_n_s[g]   <= n_c;
				div_q_s[g]   <= q_c;
				lum_sat_s[g] <= lum_sat_s[g-1];
				a_zero_s[g]  <= a_zero_s[g-1];
			end
		end
	end

	// stage 6: lum and tint numerators
	logic [7:0]  lum;
	logic [14:0] num_s6 [3];

	always_comb begin
		if (a_zero_s[5]) begin
			lum = '0;
		end else if (lum_sat_s[5]) begin
			lum = 8'd255;
		end else begin
			lum = div_q_s[5];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[6] <= ctx_s[5];
			for (int c = 0; c < 3; c++) begin
				num_s6[c] <= tint_num(ctx_s[5].tint[8*c +: 8], lum);
			end
		end
	end

	// stage 7: numerator times alpha
	logic [22:0] prod_s7 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[7] <= ctx_s[6];
			for (int c = 0; c < 3; c++) begin
				prod_s7[c] <= 23'(num_s6[c]) * 23'(ctx_s[6].src[31:24]);
			end
		end
	end

	// stage 8: /32640 = >>7 then /255; pick the pixel fed to the over stage
	// tint low byte lands on output red, high byte on output blue
	logic [7:0]  tc [3];
	logic [31:0] tinted;
	logic [31:0] base_s8;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			tc[c] = div255(prod_s7[c][22:7]);
		end
		tinted = {ctx_s[7].src[31:24], tc[0], tc[1], tc[2]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[8] <= ctx_s[7];
			if (ctx_s[7].mode == MODE_TINT || ctx_s[7].mode == MODE_TINT_OVER) begin
				base_s8 <= tinted;
			end else begin
				base_s8 <= ctx_s[7].src;
			end
		end
	end

	// stage 9: (255 - a) * dst per channel
	logic [7:0]  inv;
	logic [15:0] over_p_s9 [4];
	logic [31:0] base_s9;

	assign inv = 8'd255 - base_s8[31:24];

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[9] <= ctx_s[8];
			base_s9  <= base_s8;
			for (int c = 0; c < 4; c++) begin
				over_p_s9[c] <= 16'(inv) * 16'(ctx_s[8].dst[8*c +: 8]);
			end
		end
	end

	// stage 10: output register
	logic [31:0] over_pix;
	logic [8:0]  sum;
	logic [31:0] out_s10;

	always_comb begin
		over_pix = '0;
		for (int c = 0; c < 4; c++) begin
			sum = 9'(base_s9[8*c +: 8]) + 9'(div255(over_p_s9[c]));
			over_pix[8*c +: 8] = sum[8] ? 8'd255 : sum[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctx_s[9].mode == MODE_OVER || ctx_s[9].mode == MODE_TINT_OVER) begin
				out_s10 <= over_pix;
			end else begin
				out_s10 <= base_s9;
			end
		end
	end

	assign out_ch.out_pixel = out_s10;

	// checks
	`TAO_ASSERT_CLK(a_stall_cause,
		!in_ch.ready |-> (v_s[NS] && !out_ch.ready),
		"stall without blocked output")
	`TAO_ASSERT_CLK(a_copy_path,
		(v_s[8] && ctx_s[8].mode == MODE_COPY) |-> (base_s8 == ctx_s[8].src),
		"copy path altered pixel")
	`TAO_ASSERT_CLK(a_tint_alpha,
		(v_s[8] && ctx_s[8].mode[1]) |-> (base_s8[31:24] == ctx_s[8].src[31:24]),
		"tint changed alpha")
	`TAO_ASSERT_NEXT(a_hold, (v_s[NS] && !out_ch.ready),
		(v_s[NS] && $stable(out_s10)), "held output item changed")

endmodule
